[src/pifo_rank_queue_top_defines.svh]
// Assertion macros for the queue top level.
`ifndef PIFO_RANK_QUEUE_TOP_DEFINES_SVH
`define PIFO_RANK_QUEUE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PRQ_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("prq check failed");
// next-cycle implication
`define PRQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("prq check failed");
`else
`define PRQ_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define PRQ_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[src/prq_pkg.sv]
`timescale 1ns / 1ps
package prq_pkg;
   localparam int DEPTH_DEF     = 128;
   localparam int RANK_BITS_DEF = 32;

   // configuration reset values
   localparam logic        CIP_RST  = 1'b0;
   localparam logic [7:0]  PLIM_RST = 8'd100;
   localparam logic [31:0] BLIM_RST = 32'd1966050000;

   // register indexes
   localparam logic [1:0] CSR_COUNT_IN_PACKETS = 2'd0;
   localparam logic [1:0] CSR_PACKET_LIMIT     = 2'd1;
   localparam logic [1:0] CSR_BYTE_LIMIT       = 2'd2;

   // commands
   localparam logic [1:0] CMD_ENQ  = 2'd0;
   localparam logic [1:0] CMD_DEQ  = 2'd1;
   localparam logic [1:0] CMD_PEEK = 2'd2;

   // result status
   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_LIMIT = 3'd1;
   localparam logic [2:0] ST_FULL  = 3'd2;
   localparam logic [2:0] ST_RET   = 3'd3;
   localparam logic [2:0] ST_EMPTY = 3'd4;

   // memory read address select
   localparam logic [1:0] RA_HEAD = 2'd0;
   localparam logic [1:0] RA_PREV = 2'd1;
   localparam logic [1:0] RA_CUR  = 2'd2;
   localparam logic [1:0] RA_NEXT = 2'd3;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] rank;
      logic [15:0] pkt_size;
      logic [31:0] pkt_handle;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] out_handle;
      logic [15:0] out_size;
      logic [31:0] out_rank;
      logic [7:0]  occupancy;
      logic [31:0] byte_total;
   } rsp_word_type;

   // controller -> datapath
   typedef struct packed {
      logic       take;
      logic       set_status;
      logic [2:0] status;
      logic       set_pos_one;
      logic       pos_dec;
      logic       pos_inc;
      logic       rd_en;
      logic [1:0] rd_sel;
      logic       wr_en;
      logic       wr_prev;
      logic       wr_from_rd;
      logic       cap_out;
      logic       commit;
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic enq;
      logic deq;
      logic limit_hit;
      logic full;
      logic empty;
      logic pos_zero;
      logic rank_gt;
      logic idx_lt;
      logic next_lt;
      logic out_busy;
   } stat_type;
endpackage

[src/prq_datapath.sv]
`timescale 1ns / 1ps
module prq_datapath #(
   parameter int DEPTH     = 128,
   parameter int RANK_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [31:0]           csr_wdata,
   input  prq_pkg::req_word_type req_word,
   input  prq_pkg::ctl_type      ctl,
   output prq_pkg::stat_type     stat,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output prq_pkg::rsp_word_type rsp_word
);
   import prq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int MW = (CW > 8) ? CW : 8;

   typedef struct packed {
      logic [RANK_BITS-1:0] rank;
      logic [31:0]          handle;
      logic [15:0]          size;
   } entry_type;

   entry_type mem [0:DEPTH-1];

   logic                 cip_ff;
   logic [7:0]           plim_ff;
   logic [31:0]          blim_ff;
   logic [1:0]           cmd_ff;
   logic [RANK_BITS-1:0] rank_ff;
   logic [15:0]          size_ff;
   logic [31:0]          handle_ff;
   logic [CW-1:0]        pos_ff, pos_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [31:0]          bytes_ff, bytes_in;
   logic [2:0]           status_ff;
   logic [RANK_BITS-1:0] orank_ff;
   logic [31:0]          ohandle_ff;
   logic [15:0]          osize_ff;
   entry_type            rd_data_ff;
   logic                 rsp_valid_ff;
   rsp_word_type         rsp_word_ff, rsp_word_in;

   logic [63:0]   rank_in64, orank64;
   logic [CW-1:0] pos_m1, pos_p1;
   logic [CW:0]   pos_p1_w;
   logic [32:0]   byte_sum;
   logic [AW-1:0] rd_addr, wr_addr;
   entry_type     new_entry, wr_data;
   logic [MW-1:0] count_w;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cip_ff  <= CIP_RST;
         plim_ff <= PLIM_RST;
         blim_ff <= BLIM_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_COUNT_IN_PACKETS: cip_ff  <= csr_wdata[0];
            CSR_PACKET_LIMIT:     plim_ff <= csr_wdata[7:0];
            CSR_BYTE_LIMIT:       blim_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign rank_in64 = 64'(req_word.rank);
   assign pos_m1    = pos_ff - 1'b1;
   assign pos_p1_w  = {1'b0, pos_ff} + 1'b1;
   assign pos_p1    = pos_p1_w[CW-1:0];
   assign byte_sum  = {1'b0, bytes_ff} + 33'(size_ff);
   assign new_entry = '{rank: rank_ff, handle: handle_ff, size: size_ff};

   // status toward the controller
   always_comb begin
      stat.enq       = (cmd_ff == CMD_ENQ);
      stat.deq       = (cmd_ff == CMD_DEQ);
      stat.limit_hit = cip_ff ? (MW'(count_ff) >= MW'(plim_ff))
                              : (byte_sum >= {1'b0, blim_ff});
      stat.full      = (count_ff == CW'(DEPTH));
      stat.empty     = (count_ff == '0);
      stat.pos_zero  = (pos_ff == '0);
      stat.rank_gt   = (rd_data_ff.rank > rank_ff);
      stat.idx_lt    = (pos_ff < count_ff);
      stat.next_lt   = (pos_p1_w < {1'b0, count_ff});
      stat.out_busy  = rsp_valid_ff && !rsp_ready;
   end

   // memory addressing
   always_comb begin
      case (ctl.rd_sel)
         RA_HEAD: rd_addr = '0;
         RA_PREV: rd_addr = pos_m1[AW-1:0];
         RA_CUR:  rd_addr = pos_ff[AW-1:0];
         RA_NEXT: rd_addr = pos_p1[AW-1:0];
         default: rd_addr = '0;
      endcase
      wr_addr = ctl.wr_prev ? pos_m1[AW-1:0] : pos_ff[AW-1:0];
      wr_data = ctl.wr_from_rd ? rd_data_ff : new_entry;
   end

   // sorted entry store
   always_ff @(posedge clock) begin
      if (ctl.wr_en) mem[wr_addr] <= wr_data;
      if (ctl.rd_en) rd_data_ff <= mem[rd_addr];
   end

   // item and walk position
   always_comb begin
      pos_in = pos_ff;
      if (ctl.take)             pos_in = count_ff;
      else if (ctl.set_pos_one) pos_in = CW'(1);
      else if (ctl.pos_dec)     pos_in = pos_m1;
      else if (ctl.pos_inc)     pos_in = pos_p1;
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      if (ctl.take) begin
         cmd_ff     <= req_word.cmd;
         rank_ff    <= rank_in64[RANK_BITS-1:0];
         size_ff    <= req_word.pkt_size;
         handle_ff  <= req_word.pkt_handle;
         orank_ff   <= '0;
         ohandle_ff <= '0;
         osize_ff   <= '0;
      end else if (ctl.cap_out) begin
         orank_ff   <= rd_data_ff.rank;
         ohandle_ff <= rd_data_ff.handle;
         osize_ff   <= rd_data_ff.size;
      end
      if (ctl.set_status) status_ff <= ctl.status;
   end

   // occupancy and byte total after this word
   always_comb begin
      count_in = count_ff;
      bytes_in = bytes_ff;
      if (status_ff == ST_OK) begin
         count_in = count_ff + 1'b1;
         bytes_in = byte_sum[31:0];
      end else if (status_ff == ST_RET && cmd_ff == CMD_DEQ) begin
         count_in = count_ff - 1'b1;
         bytes_in = bytes_ff - 32'(osize_ff);
      end
   end

   assign orank64 = 64'(orank_ff);
   assign count_w = MW'(count_in);

   always_comb begin
      rsp_word_in.status     = status_ff;
      rsp_word_in.out_handle = ohandle_ff;
      rsp_word_in.out_size   = osize_ff;
      rsp_word_in.out_rank   = orank64[31:0];
      rsp_word_in.occupancy  = count_w[7:0];
      rsp_word_in.byte_total = bytes_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         bytes_ff <= '0;
      end else if (ctl.commit) begin
         count_ff <= count_in;
         bytes_ff <= bytes_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (ctl.commit) rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
endmodule

[src/prq_ctrl.sv]
`timescale 1ns / 1ps
module prq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  prq_pkg::stat_type  stat,
   output prq_pkg::ctl_type   ctl
);
   import prq_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EVAL  = 3'd1;
   localparam logic [2:0] S_INS   = 3'd2;
   localparam logic [2:0] S_CMP   = 3'd3;
   localparam logic [2:0] S_HEAD  = 3'd4;
   localparam logic [2:0] S_SHIFT = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0] state_ff, state_in;

   always_comb begin
      ctl       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.take = 1'b1;
               state_in = S_EVAL;
            end
         end
         // drop checks or head read
         S_EVAL: begin
            ctl.set_status = 1'b1;
            if (stat.enq) begin
               if (stat.limit_hit) begin
                  ctl.status = ST_LIMIT;
                  state_in   = S_DONE;
               end else if (stat.full) begin
                  ctl.status = ST_FULL;
                  state_in   = S_DONE;
               end else begin
                  ctl.status = ST_OK;
                  state_in   = S_INS;
               end
            end else if (stat.empty) begin
               ctl.status = ST_EMPTY;
               state_in   = S_DONE;
            end else begin
               ctl.status      = ST_RET;
               ctl.rd_en       = 1'b1;
               ctl.rd_sel      = RA_HEAD;
               ctl.set_pos_one = 1'b1;
               state_in        = S_HEAD;
            end
         end
         // insertion walk from the tail
         S_INS: begin
            if (stat.pos_zero) begin
               ctl.wr_en = 1'b1;
               state_in  = S_DONE;
            end else begin
               ctl.rd_en  = 1'b1;
               ctl.rd_sel = RA_PREV;
               state_in   = S_CMP;
            end
         end
         S_CMP: begin
            ctl.wr_en = 1'b1;
            if (stat.rank_gt) begin
               ctl.wr_from_rd = 1'b1;
               ctl.pos_dec    = 1'b1;
               state_in       = S_INS;
            end else begin
               state_in = S_DONE;
            end
         end
         // head entry is out of the memory
         S_HEAD: begin
            ctl.cap_out = 1'b1;
            if (stat.deq && stat.idx_lt) begin
               ctl.rd_en  = 1'b1;
               ctl.rd_sel = RA_CUR;
               state_in   = S_SHIFT;
            end else begin
               state_in = S_DONE;
            end
         end
         // move entries one slot toward the head
         S_SHIFT: begin
            ctl.wr_en      = 1'b1;
            ctl.wr_prev    = 1'b1;
            ctl.wr_from_rd = 1'b1;
            if (stat.next_lt) begin
               ctl.rd_en   = 1'b1;
               ctl.rd_sel  = RA_NEXT;
               ctl.pos_inc = 1'b1;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!stat.out_busy) begin
               ctl.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end
endmodule

[src/pifo_rank_queue_top.sv]
// Push-in first-out queue of packet descriptors, lowest rank served first,
// first-come order among equal ranks.
// Request channel (req_valid/req_ready/req_word): one command per word,
// enqueue, dequeue or peek. Response channel (rsp_valid/rsp_ready/rsp_word):
// exactly one word per request, with status, returned entry, occupancy and
// byte total. Configuration: csr_we/csr_index/csr_wdata, written while idle.
// Entries are kept sorted in a single-port-write, registered-read memory, so
// the work is set by that memory port, one entry move at a time:
//   drop or empty: the response is loaded straight after the checks
//   enqueue: walks down from the tail, moving each stored entry of higher
//   rank one slot up, then writes the new entry
//   peek reads the head; dequeue also moves the later entries forward
// One request is in work at a time; req_ready rises again once the response
// is loaded. The response register holds while rsp_ready is low; a finished
// word then waits in the controller until the register frees.
// Reset (synchronous) empties the queue and restores the limits.
`timescale 1ns / 1ps
`include "pifo_rank_queue_top_defines.svh"
module pifo_rank_queue_top #(
   parameter int DEPTH     = prq_pkg::DEPTH_DEF,
   parameter int RANK_BITS = prq_pkg::RANK_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [31:0]           csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  prq_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output prq_pkg::rsp_word_type rsp_word
);
   import prq_pkg::*;

   ctl_type  ctl;
   stat_type stat;

   prq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   prq_datapath #(
      .DEPTH     (DEPTH),
      .RANK_BITS (RANK_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_word  (req_word),
      .ctl       (ctl),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   // checks
   `PRQ_ASSERT_NEXT(a_busy_after_take, clock, reset, req_valid && req_ready, !req_ready)
   `PRQ_ASSERT_NEXT(a_commit_shows, clock, reset, ctl.commit, rsp_valid)
   `PRQ_ASSERT_NOW(a_empty_zero, clock, reset, rsp_valid && rsp_word.status == ST_EMPTY, rsp_word.occupancy == 8'd0 && rsp_word.out_handle == 32'd0)
   `PRQ_ASSERT_NOW(a_no_mem_write_idle, clock, reset, req_ready, !ctl.wr_en && !ctl.rd_en)
endmodule

[bench/pifo_checker.sv]
`timescale 1ns / 1ps
module pifo_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [31:0]           csr_wdata,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  prq_pkg::req_word_type req_word,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  prq_pkg::rsp_word_type rsp_word,
   output int                    fail_count,
   output int                    pending,
   output int                    rsp_seen,
   output int                    occ_now
);
   import prq_pkg::*;

   localparam int DEPTH = DEPTH_DEF;

   // shadow copy of the queue and its limits
   logic        by_packets;
   logic [7:0]  pkt_cap;
   logic [31:0] byte_cap;
   logic [31:0] sh_rank   [DEPTH];
   logic [31:0] sh_handle [DEPTH];
   logic [15:0] sh_size   [DEPTH];
   int          sh_count;
   logic [31:0] sh_bytes;
   rsp_word_type expected_words[$];

   assign pending = expected_words.size();
   assign occ_now = sh_count;

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   // compute the response word for one request and update the shadow queue
   function automatic rsp_word_type serve_request(input req_word_type rq);
      rsp_word_type r;
      logic hit;
      int pos;
      r = '0;
      if (rq.cmd == CMD_ENQ) begin
         if (by_packets) hit = (sh_count >= pkt_cap);
         else hit = ({1'b0, sh_bytes} + 33'(rq.pkt_size)) >= {1'b0, byte_cap};
         if (hit) r.status = ST_LIMIT;
         else if (sh_count >= DEPTH) r.status = ST_FULL;
         else begin
            pos = sh_count;
            while (pos > 0 && sh_rank[pos-1] > rq.rank) begin
               sh_rank[pos]   = sh_rank[pos-1];
               sh_handle[pos] = sh_handle[pos-1];
               sh_size[pos]   = sh_size[pos-1];
               pos--;
            end
            sh_rank[pos]   = rq.rank;
            sh_handle[pos] = rq.pkt_handle;
            sh_size[pos]   = rq.pkt_size;
            sh_count++;
            sh_bytes += rq.pkt_size;
            r.status = ST_OK;
         end
      end else if (sh_count == 0) begin
         r.status = ST_EMPTY;
      end else begin
         r.status     = ST_RET;
         r.out_rank   = sh_rank[0];
         r.out_handle = sh_handle[0];
         r.out_size   = sh_size[0];
         // deq removes the head; peek and the unused code leave it
         if (rq.cmd == CMD_DEQ) begin
            for (int i = 1; i < sh_count; i++) begin
               sh_rank[i-1]   = sh_rank[i];
               sh_handle[i-1] = sh_handle[i];
               sh_size[i-1]   = sh_size[i];
            end
            sh_count--;
            sh_bytes -= r.out_size;
         end
      end
      r.occupancy  = sh_count[7:0];
      r.byte_total = sh_bytes;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_word_type w;
      if (reset) begin
         by_packets = CIP_RST;
         pkt_cap    = PLIM_RST;
         byte_cap   = BLIM_RST;
         sh_count   = 0;
         sh_bytes   = '0;
         fail_count = 0;
         rsp_seen   = 0;
         expected_words.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_COUNT_IN_PACKETS: by_packets = csr_wdata[0];
               CSR_PACKET_LIMIT:     pkt_cap    = csr_wdata[7:0];
               CSR_BYTE_LIMIT:       byte_cap   = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            rsp_seen++;
            if (expected_words.size() == 0) begin
               report("unexpected word", rsp_word.status, 0);
            end else begin
               w = expected_words.pop_front();
               if (rsp_word.status !== w.status) report("status", rsp_word.status, w.status);
               if (rsp_word.out_handle !== w.out_handle)
                  report("out_handle", rsp_word.out_handle, w.out_handle);
               if (rsp_word.out_size !== w.out_size)
                  report("out_size", rsp_word.out_size, w.out_size);
               if (rsp_word.out_rank !== w.out_rank)
                  report("out_rank", rsp_word.out_rank, w.out_rank);
               if (rsp_word.occupancy !== w.occupancy)
                  report("occupancy", rsp_word.occupancy, w.occupancy);
               if (rsp_word.byte_total !== w.byte_total)
                  report("byte_total", rsp_word.byte_total, w.byte_total);
            end
         end
         if (req_valid && req_ready) expected_words.push_back(serve_request(req_word));
      end
   end
endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
module tb;
   import prq_pkg::*;

   // spare command code, served as a peek
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic         clock;
   logic         reset;
   logic         csr_we;
   logic [1:0]   csr_index;
   logic [31:0]  csr_wdata;
   logic         req_valid;
   logic         req_ready;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_word_type rsp_word;
   int           fail_count;
   int           pending;
   int           rsp_seen;
   int           occ_now;
   int           cycle_count;
   int           hold_off;
   int           sent;
   bit           stim_done;

   pifo_rank_queue_top dut (.*);

   pifo_checker chk (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // watchdog
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > 2000000) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // receiver: random stalls per word, plus a long hold-off on request
   initial begin
      int waits;
      rsp_ready <= 1'b0;
      @(posedge clock iff !reset);
      forever begin
         if (hold_off > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_off) @(posedge clock);
            hold_off = 0;
         end
         waits = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
         if (waits > 0) begin
            rsp_ready <= 1'b0;
            repeat (waits) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // offer one word, hold it until taken; gaps drawn per word
   task automatic send_word(input logic [1:0] c, input logic [31:0] rk,
                            input logic [15:0] sz, input logic [31:0] hd, input bit gaps);
      int waits;
      waits = (gaps && $urandom_range(0, 2) != 0) ? $urandom_range(0, 17) : 0;
      if (waits > 0) begin
         req_valid <= 1'b0;
         repeat (waits) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= '{cmd: c, rank: rk, pkt_size: sz, pkt_handle: hd};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_rank();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 7);
         1: return 32'hFFFF_FFF8 | $urandom_range(0, 7);
         default: return $urandom();
      endcase
   endfunction

   // random mix: mostly enqueues and dequeues, some peeks and code three
   task automatic random_burst(input int n, input int enq_pct, input bit small_sizes);
      int p;
      logic [1:0] c;
      for (int i = 0; i < n; i++) begin
         p = $urandom_range(0, 99);
         if (p < enq_pct) c = CMD_ENQ;
         else if (p < enq_pct + (100 - enq_pct) * 3 / 4) c = CMD_DEQ;
         else if (p % 3 == 0) c = CMD_UNUSED;
         else c = CMD_PEEK;
         send_word(c, rand_rank(), small_sizes ? 16'($urandom_range(0, 300)) : 16'($urandom()),
                   $urandom(), 1'b1);
      end
   endtask

   initial begin
      reset     <= 1'b1;
      csr_we    <= 1'b0;
      csr_index <= CSR_COUNT_IN_PACKETS;
      csr_wdata <= '0;
      req_valid <= 1'b0;
      req_word  <= '0;
      hold_off  = 0;
      sent      = 0;
      stim_done = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty reads, extremes, ties, unused command
      send_word(CMD_DEQ, 0, 0, 0, 0);
      send_word(CMD_PEEK, 0, 0, 0, 0);
      send_word(CMD_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 0);
      send_word(CMD_ENQ, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 0);
      send_word(CMD_ENQ, 0, 0, 32'h0, 0);
      send_word(CMD_ENQ, 5, 10, 32'hA, 0);
      send_word(CMD_ENQ, 5, 11, 32'hB, 0);
      send_word(CMD_ENQ, 5, 12, 32'hC, 0);
      send_word(CMD_PEEK, 0, 0, 0, 0);
      send_word(CMD_UNUSED, 0, 0, 0, 0);
      repeat (6) send_word(CMD_DEQ, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 0);
      drain();

      // byte mode: limit reached exactly and no wrap above the top
      csr_write(CSR_BYTE_LIMIT, 32'd100);
      send_word(CMD_ENQ, 1, 99, 1, 0);
      send_word(CMD_ENQ, 1, 100, 2, 0);
      send_word(CMD_ENQ, 1, 98, 3, 0);
      send_word(CMD_ENQ, 1, 1, 4, 0);
      send_word(CMD_DEQ, 0, 0, 0, 0);
      drain();
      csr_write(CSR_BYTE_LIMIT, 32'hFFFF_FFFF);
      csr_write(CSR_COUNT_IN_PACKETS, 32'hFFFF_FFFE);
      send_word(CMD_ENQ, 3, 65535, 5, 0);
      send_word(CMD_DEQ, 0, 0, 0, 0);
      drain();

      // packet mode, limit zero: every enqueue dropped by limit
      csr_write(CSR_COUNT_IN_PACKETS, 32'd1);
      csr_write(CSR_PACKET_LIMIT, 32'd0);
      send_word(CMD_ENQ, 7, 7, 7, 0);
      drain();

      // packet mode at 128: fill the store, drops by limit, long receiver hold-off
      csr_write(CSR_PACKET_LIMIT, 32'hFFFF_FF80);
      hold_off = 400;
      random_burst(140, 100, 0);
      drain();
      random_burst(150, 20, 0);
      drain();

      // packet limit above depth: store-full drops
      csr_write(CSR_PACKET_LIMIT, 32'd255);
      random_burst(135, 100, 0);
      random_burst(140, 15, 0);
      drain();

      // small packet limit, mixed traffic
      csr_write(CSR_PACKET_LIMIT, 32'd6);
      random_burst(120, 55, 0);
      drain();

      // byte mode with a tight limit, short queues
      csr_write(CSR_COUNT_IN_PACKETS, 32'd0);
      csr_write(CSR_BYTE_LIMIT, 32'd2000);
      random_burst(110, 55, 1);
      drain();
      csr_write(CSR_BYTE_LIMIT, 32'd0);
      send_word(CMD_ENQ, 1, 0, 1, 0);
      drain();
      csr_write(CSR_BYTE_LIMIT, BLIM_RST);
      random_burst(40, 50, 0);
      random_burst(40, 5, 0);
      drain();

      $display("Sent %0d request words, checked %0d responses in packet and byte modes,",
               sent, rsp_seen);
      $display("covering limit drops, store-full drops, empty reads, peeks and rank ties.");
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule

[filelist.f]
+incdir+src
src/prq_pkg.sv
src/prq_datapath.sv
src/prq_ctrl.sv
src/pifo_rank_queue_top.sv
bench/pifo_checker.sv
bench/tb.sv
